/* rtl/wstfe_pkg.sv */
// shared types, constants and helpers for the websocket text frame encoder
`default_nettype none

package wstfe_pkg;

	// request kinds on the input channel
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_BYTE  = 1'b1;

	// frame constants
	localparam logic [7:0]  HDR_TEXT_FIN  = 8'h81;
	localparam logic [15:0] SHORT_LEN_MAX = 16'd125;
	localparam logic [7:0]  MASK_BIT      = 8'h80;
	localparam logic [7:0]  LEN16_CODE    = 8'd254;

	// command queue between front and back, depth must be a power of two
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	// expansion step counter, long header takes eight bytes
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_LAST_SHORT = 3'd5;
	localparam logic [STEP_W-1:0] STEP_LAST_LONG  = 3'd7;
	localparam logic [STEP_W-1:0] STEP_MASK_SHORT = 3'd2;
	localparam logic [STEP_W-1:0] STEP_MASK_LONG  = 3'd4;

	// one queued command: a frame start or a finished payload byte
	typedef struct packed {
		logic        kind;
		logic [15:0] len;
		logic [31:0] key;
		logic [7:0]  pbyte;
		logic        frame_last;
		logic        excess;
	} cmd_t;

	// mask byte idx, first byte from bits 31:24
	function automatic logic [7:0] mask_byte(input logic [31:0] key, input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (idx)
			2'd0: b = key[31:24];
			2'd1: b = key[23:16];
			2'd2: b = key[15:8];
			2'd3: b = key[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

/* rtl/websocket_text_frame_encoder_unit.sv */
// top level of the client websocket masked text frame encoder
//
// input channel: push/full. a beat with req_type start carries payload_len
// and mask_key and opens a frame; a beat with req_type byte carries one raw
// payload byte. output channel: empty/pop, one frame byte per beat with
// run_last, frame_last and excess flags.
// a start beat expands to 6 bytes (length up to 125) or 8 bytes (16-bit
// length); a payload beat gives one byte. a beat's first byte goes through
// the command queue and then the output register. payload beats flow at
// one per cycle while the receiver keeps popping; a start beat holds the
// back end while its expansion sequencer gives header bytes one per cycle,
// and the front keeps taking beats into a 4-entry command queue until full.
// masking state is updated at accept time in the front, so the queue holds
// finished payload bytes.
// reset clears frame state, queue pointers and the output valid flag; no frame is open.
// when the receiver holds off pop, the output register keeps its byte, the
// queue fills, and full rises toward the sender.
`default_nettype none

module websocket_text_frame_encoder_unit
	import wstfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        req_type,
	input  wire logic [15:0] payload_len,
	input  wire logic [31:0] mask_key,
	input  wire logic [7:0]  payload_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             frame_last,
	output logic             excess
);

	cmd_t cmd_wdata;
	cmd_t cmd_rdata;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;

	wstfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.payload_len  (payload_len),
		.mask_key     (mask_key),
		.payload_byte (payload_byte),
		.cmd_push     (cmd_push),
		.cmd_full     (cmd_full),
		.cmd_wdata    (cmd_wdata)
	);

	wstfe_cmd_fifo u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_wdata),
		.full   (cmd_full),
		.rd     (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	wstfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_rdata),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_last (frame_last),
		.excess     (excess)
	);

endmodule

`default_nettype wire

/* rtl/wstfe_front.sv */
// front: accepts request beats, tracks frame state and queues commands
`default_nettype none

module wstfe_front
	import wstfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        req_type,
	input  wire logic [15:0] payload_len,
	input  wire logic [31:0] mask_key,
	input  wire logic [7:0]  payload_byte,
	output logic             cmd_push,
	input  wire logic        cmd_full,
	output cmd_t             cmd_wdata
);

	logic [31:0] mask_q;
	logic [1:0]  phase_q;
	logic [15:0] left_q;
	logic        acc;
	logic        in_frame;

	assign full     = cmd_full;
	assign acc      = push && !cmd_full;
	assign cmd_push = acc;
	assign in_frame = (left_q != 16'd0);

	always_comb begin
		cmd_wdata.kind       = req_type;
		cmd_wdata.len        = payload_len;
		cmd_wdata.key        = mask_key;
		cmd_wdata.pbyte      = 8'h00;
		cmd_wdata.frame_last = 1'b0;
		cmd_wdata.excess     = 1'b0;
		if (req_type == REQ_BYTE) begin
			if (in_frame) begin
				cmd_wdata.pbyte      = payload_byte ^ mask_byte(mask_q, phase_q);
				cmd_wdata.frame_last = (left_q == 16'd1);
			end else begin
				cmd_wdata.excess = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			phase_q <= '0;
			left_q  <= '0;
		end else if (acc) begin
			if (req_type == REQ_START) begin
				mask_q  <= mask_key;
				phase_q <= '0;
				left_q  <= payload_len;
			end else if (in_frame) begin
				phase_q <= phase_q + 2'd1;
				left_q  <= left_q - 16'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/wstfe_cmd_fifo.sv */
// short command queue between front and back
`default_nettype none

module wstfe_cmd_fifo
	import wstfe_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire cmd_t wdata,
	output logic      full,
	input  wire logic rd,
	output cmd_t      rdata,
	output logic      empty
);

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wptr_q;
	logic [CMDQ_AW-1:0] rptr_q;
	logic [CMDQ_CW-1:0] count_q;
	logic               do_wr;
	logic               do_rd;

	assign full  = (count_q == CMDQ_CW'(CMDQ_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CMDQ_CW'(CMDQ_DEPTH))
		else $error("command queue count out of range");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("command queue count lost a write");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wptr_q - rptr_q) == count_q[CMDQ_AW-1:0])
		else $error("command queue pointers disagree with count");

endmodule

`default_nettype wire

/* rtl/wstfe_back.sv */
// back: expands queued commands into frame bytes behind an output register
`default_nettype none

module wstfe_back
	import wstfe_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic cmd_empty,
	output logic      cmd_pop,
	output logic      empty,
	input  wire logic pop,
	output logic [7:0] out_byte,
	output logic      run_last,
	output logic      frame_last,
	output logic      excess
);

	logic [STEP_W-1:0] step_q;
	logic              valid_q;
	logic [7:0]        byte_q;
	logic              run_last_q;
	logic              frame_last_q;
	logic              excess_q;

	logic              is_start;
	logic              is_long;
	logic [STEP_W-1:0] last_step;
	logic [STEP_W-1:0] mask_base;
	logic [1:0]        midx;
	logic              start_done;
	logic              out_take;
	logic              ld;
	logic [7:0]        nxt_byte;

	assign is_start   = (cmd.kind == REQ_START);
	assign is_long    = (cmd.len > SHORT_LEN_MAX);
	assign last_step  = is_long ? STEP_LAST_LONG : STEP_LAST_SHORT;
	assign mask_base  = is_long ? STEP_MASK_LONG : STEP_MASK_SHORT;
	assign midx       = 2'(step_q - mask_base);
	assign start_done = (step_q == last_step);
	assign out_take   = pop && valid_q;
	assign ld         = !cmd_empty && (!valid_q || out_take);
	assign cmd_pop    = ld && (!is_start || start_done);

	// header byte for the current step of a start command
	always_comb begin
		priority if (step_q == '0) begin
			nxt_byte = HDR_TEXT_FIN;
		end else if (step_q == 3'd1) begin
			nxt_byte = is_long ? LEN16_CODE : (MASK_BIT | cmd.len[7:0]);
		end else if (is_long && step_q == 3'd2) begin
			nxt_byte = cmd.len[15:8];
		end else if (is_long && step_q == 3'd3) begin
			nxt_byte = cmd.len[7:0];
		end else begin
			nxt_byte = mask_byte(cmd.key, midx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (ld) begin
				valid_q <= 1'b1;
				if (is_start && !start_done) begin
					step_q <= step_q + 1'b1;
				end else begin
					step_q <= '0;
				end
			end else if (out_take) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			if (is_start) begin
				byte_q       <= nxt_byte;
				run_last_q   <= start_done;
				frame_last_q <= 1'b0;
				excess_q     <= 1'b0;
			end else begin
				byte_q       <= cmd.pbyte;
				run_last_q   <= 1'b1;
				frame_last_q <= cmd.frame_last;
				excess_q     <= cmd.excess;
			end
		end
	end

	assign empty      = !valid_q;
	assign out_byte   = byte_q;
	assign run_last   = run_last_q;
	assign frame_last = frame_last_q;
	assign excess     = excess_q;

	a_step_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != '0) |-> (!cmd_empty && is_start))
		else $error("expansion step active without a start command at the head");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != '0 && !is_long) |-> (step_q <= STEP_LAST_SHORT))
		else $error("short header expansion ran past its last step");

	a_pop_on_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (valid_q && run_last_q))
		else $error("command retired without closing its run");

endmodule

`default_nettype wire
